// ----- hdl/sfh_pkg.sv -----
// ----------------------------------------------------------------------------
// sfh_pkg
// Shared types and constants for the superfasthash bucket index block.
// ----------------------------------------------------------------------------
package sfh_pkg;

  localparam int HashW    = 32;
  localparam int KeyLenW  = 16;
  localparam int StepW    = 2;
  localparam int DivCntW  = 6;

  // mixing shift amounts
  localparam int ShHiMix   = 11;
  localparam int ShHalf    = 16;
  localparam int ShTail3   = 18;
  localparam int ShTail2Dn = 17;
  localparam int ShTail1   = 10;
  localparam int ShAv25    = 25;

  localparam logic [StepW-1:0] FinLast = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FINISH,
    ST_DIV_START,
    ST_DIV_WAIT
  } sfh_state_t;

  typedef struct packed {
    logic             accept;
    logic             fin_step;
    logic [StepW-1:0] fin_sel;
    logic             div_start;
    logic             out_load;
    logic             out_zero;
  } sfh_cmd_t;

  typedef struct packed {
    logic zero_len;
    logic last;
    logic div_done;
  } sfh_status_t;

  function automatic logic [HashW-1:0] sext8(input logic [7:0] b);
    return {{(HashW-8){b[7]}}, b};
  endfunction

endpackage

// ----- hdl/sfh_in_if.sv -----
// ----------------------------------------------------------------------------
// sfh_in_if
// Key chunk channel: valid/ready with chunk, key length and start flag.
// ----------------------------------------------------------------------------
interface sfh_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] chunk;
  logic [15:0] key_length;
  logic        key_start;

  modport source (output valid, chunk, key_length, key_start, input ready);
  modport sink   (input valid, chunk, key_length, key_start, output ready);
endinterface

// ----- hdl/sfh_out_if.sv -----
// ----------------------------------------------------------------------------
// sfh_out_if
// Bucket index channel: valid/ready with the reduced hash.
// ----------------------------------------------------------------------------
interface sfh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] bucket_index;

  modport source (output valid, bucket_index, input ready);
  modport sink   (input valid, bucket_index, output ready);
endinterface

// ----- hdl/superfasthash_bucket_index.sv -----
// ----------------------------------------------------------------------------
// superfasthash_bucket_index
// Streams key chunks through a 32-bit hash and reduces it modulo table_size.
//
//   channel   dir  beat payload
//   chunks    in   chunk[31:0], key_length[15:0], key_start
//   buckets   out  bucket_index[31:0]
//   cfg       in   cfg_we, cfg_wdata[31:0] (table_size)
//
// a chunk that does not end its key is absorbed and the block stays idle
// a key's last chunk is followed by 3 avalanche steps, a divide start, the
// divide in the radix-2 remainder unit and a result load once the output
// slot is free; a zero-length key gives its beat next cycle
// synchronous reset, no clearing pass; chunks are held off while a result
// beat is pending and not taken
// ----------------------------------------------------------------------------
module superfasthash_bucket_index #(
  parameter int LENGTH_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  sfh_in_if.sink      chunks,
  sfh_out_if.source   buckets
);
  import sfh_pkg::*;

  sfh_cmd_t    cmd;
  sfh_status_t status;

  sfh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (chunks.valid),
    .in_ready  (chunks.ready),
    .out_valid (buckets.valid),
    .out_ready (buckets.ready),
    .status    (status),
    .cmd       (cmd)
  );

  sfh_datapath #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .chunk        (chunks.chunk),
    .key_length   (chunks.key_length),
    .key_start    (chunks.key_start),
    .cmd          (cmd),
    .status       (status),
    .bucket_index (buckets.bucket_index)
  );

endmodule

// ----- hdl/sfh_div.sv -----
// ----------------------------------------------------------------------------
// sfh_div
// Restoring radix-2 remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sfh_div (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [sfh_pkg::HashW-1:0] dividend,
  input  logic [sfh_pkg::HashW-1:0] divisor,
  output logic                 done,
  output logic [sfh_pkg::HashW-1:0] remainder
);
  import sfh_pkg::*;

  logic [HashW-1:0]   quo;
  logic [HashW-1:0]   rem;
  logic [DivCntW-1:0] count;
  logic               busy;
  logic [HashW:0]     shifted;
  logic [HashW:0]     diff;

  assign shifted = {rem, quo[HashW-1]};
  assign diff    = shifted - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      done  <= 1'b0;
      count <= DivCntW'(HashW);
    end else if (busy) begin
      count <= count - 1'b1;
      if (count == DivCntW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[HashW-2:0], 1'b0};
      if (!diff[HashW]) begin
        rem <= diff[HashW-1:0];
      end else begin
        rem <= shifted[HashW-1:0];
      end
    end
  end

  assign remainder = rem;

endmodule

// ----- hdl/sfh_datapath.sv -----
// ----------------------------------------------------------------------------
// sfh_datapath
// Hash accumulator, chunk mixing, avalanche steps, modulo and result register.
// ----------------------------------------------------------------------------
module sfh_datapath #(
  parameter int LENGTH_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [sfh_pkg::HashW-1:0]   cfg_wdata,
  input  logic [31:0]                 chunk,
  input  logic [sfh_pkg::KeyLenW-1:0] key_length,
  input  logic                        key_start,
  input  sfh_pkg::sfh_cmd_t           cmd,
  output sfh_pkg::sfh_status_t        status,
  output logic [sfh_pkg::HashW-1:0]   bucket_index
);
  import sfh_pkg::*;

  logic [HashW-1:0]       table_size;
  logic [HashW-1:0]       hash;
  logic [LENGTH_BITS-1:0] remaining;
  logic                   active;

  logic [LENGTH_BITS-1:0] len;
  logic [HashW-1:0]       base_h;
  logic [LENGTH_BITS-1:0] base_cnt;
  logic                   take;
  logic                   full;
  logic [HashW-1:0]       lo;
  logic [HashW-1:0]       hi;
  logic [HashW-1:0]       m1, m2, m3, mixed;
  logic [HashW-1:0]       f1, fin_h;
  logic [HashW-1:0]       rem;
  logic                   div_done;

  assign len      = LENGTH_BITS'(key_length);
  assign base_h   = key_start ? HashW'(len) : hash;
  assign base_cnt = key_start ? len : remaining;
  assign take     = key_start || active;
  assign full     = base_cnt >= LENGTH_BITS'(4);
  assign lo       = {16'd0, chunk[15:0]};
  assign hi       = {16'd0, chunk[31:16]};

  always_comb begin
    m1 = '0;
    m2 = '0;
    m3 = '0;
    mixed = '0;
    if (full) begin
      m1    = base_h + lo;
      m2    = (m1 << ShHalf) ^ ((hi << ShHiMix) ^ m1);
      mixed = m2 + (m2 >> ShHiMix);
    end else if (base_cnt == LENGTH_BITS'(3)) begin
      m1    = base_h + lo;
      m2    = m1 ^ (m1 << ShHalf);
      m3    = m2 ^ (sext8(chunk[23:16]) << ShTail3);
      mixed = m3 + (m3 >> ShHiMix);
    end else if (base_cnt == LENGTH_BITS'(2)) begin
      m1    = base_h + lo;
      m2    = m1 ^ (m1 << ShHiMix);
      mixed = m2 + (m2 >> ShTail2Dn);
    end else begin
      m1    = base_h + sext8(chunk[7:0]);
      m2    = m1 ^ (m1 << ShTail1);
      mixed = m2 + (m2 >> 1);
    end
  end

  // avalanche, one xor-shift and add pair per step
  always_comb begin
    unique case (cmd.fin_sel)
      2'd0: begin
        f1    = hash ^ (hash << 3);
        fin_h = f1 + (f1 >> 5);
      end
      2'd1: begin
        f1    = hash ^ (hash << 4);
        fin_h = f1 + (f1 >> ShTail2Dn);
      end
      default: begin
        f1    = hash ^ (hash << ShAv25);
        fin_h = f1 + (f1 >> 6);
      end
    endcase
  end

  assign status.zero_len = key_start && (len == '0);
  assign status.last     = take && (base_cnt <= LENGTH_BITS'(4));
  assign status.div_done = div_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= HashW'(1);
    end else if (cfg_we) begin
      table_size <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash      <= '0;
      remaining <= '0;
      active    <= 1'b0;
    end else if (cmd.accept && status.zero_len) begin
      hash      <= '0;
      remaining <= '0;
      active    <= 1'b0;
    end else if (cmd.accept && take) begin
      hash      <= mixed;
      remaining <= full ? base_cnt - LENGTH_BITS'(4) : '0;
      active    <= !status.last;
    end else if (cmd.fin_step) begin
      hash <= fin_h;
    end
  end

  sfh_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (hash),
    .divisor   (table_size),
    .done      (div_done),
    .remainder (rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (cmd.out_zero || table_size == '0) begin
        bucket_index <= '0;
      end else begin
        bucket_index <= rem;
      end
    end
  end

endmodule

// ----- hdl/sfh_ctrl.sv -----
// ----------------------------------------------------------------------------
// sfh_ctrl
// Sequencer for accept, avalanche steps, modulo and result handoff.
// ----------------------------------------------------------------------------
module sfh_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  sfh_pkg::sfh_status_t status,
  output sfh_pkg::sfh_cmd_t    cmd
);
  import sfh_pkg::*;

  sfh_state_t       state, state_next;
  logic [StepW-1:0] fin_cnt;
  logic             slot;
  logic             accept;

  assign slot   = !out_valid || out_ready;
  assign accept = in_valid && in_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (accept && status.last && !status.zero_len) state_next = ST_FINISH;
      ST_FINISH:    if (fin_cnt == FinLast) state_next = ST_DIV_START;
      ST_DIV_START: state_next = ST_DIV_WAIT;
      ST_DIV_WAIT:  if (status.div_done && slot) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = (state == ST_IDLE) && slot;
    cmd.accept    = accept;
    cmd.fin_step  = (state == ST_FINISH);
    cmd.fin_sel   = fin_cnt;
    cmd.div_start = (state == ST_DIV_START);
    cmd.out_zero  = (state == ST_IDLE);
    cmd.out_load  = (accept && status.zero_len) ||
                    ((state == ST_DIV_WAIT) && status.div_done && slot);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fin_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_FINISH) begin
        fin_cnt <= fin_cnt + 1'b1;
      end else begin
        fin_cnt <= '0;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
